@@ hw/rtl/i2cmra_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master register access: shared definitions
// Phase codes, request kinds, register indexes, bundle types and the small
// decode functions used by the bus sequencer.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

	localparam int DivWidth = 10;

	// Request kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEVICE_ADDRESS     = 2'd0;
	localparam logic [1:0] CFG_USE_DEVICE_ADDRESS = 2'd1;
	localparam logic [1:0] CFG_HALF_PERIOD_TICKS  = 2'd2;

	// Sequencer phases
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_START  = 4'd1;
	localparam logic [3:0] PH_DEVW   = 4'd2;
	localparam logic [3:0] PH_ACK1   = 4'd3;
	localparam logic [3:0] PH_REG    = 4'd4;
	localparam logic [3:0] PH_ACK2   = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_ACK3   = 4'd7;
	localparam logic [3:0] PH_RSTART = 4'd8;
	localparam logic [3:0] PH_DEVR   = 4'd9;
	localparam logic [3:0] PH_ACK4   = 4'd10;
	localparam logic [3:0] PH_READ   = 4'd11;
	localparam logic [3:0] PH_NACK   = 4'd12;
	localparam logic [3:0] PH_STOP   = 4'd13;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] target_reg;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [6:0]          device_address;
		logic                use_device_address;
		logic [DivWidth-1:0] half_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} result_t;

	function automatic logic is_send_byte(input logic [3:0] ph);
		return (ph == PH_DEVW) || (ph == PH_REG) || (ph == PH_DATA) || (ph == PH_DEVR);
	endfunction

	// Number of half steps in a phase; sixteen wraps to zero in the 4-bit counter.
	function automatic logic [3:0] halves_of(input logic [3:0] ph);
		logic [3:0] n;
		if (is_send_byte(ph) || ph == PH_READ) begin
			n = 4'd0;
		end else if (ph == PH_RSTART || ph == PH_STOP) begin
			n = 4'd3;
		end else begin
			n = 4'd2;
		end
		return n;
	endfunction

	// Line levels {scl, sda} for the current half step.
	function automatic logic [1:0] drive(input logic [3:0] ph, input logic [3:0] bc,
			input logic msb);
		logic [1:0] lv;
		if (ph == PH_START) begin
			lv = bc[0] ? 2'b10 : 2'b11;
		end else if (is_send_byte(ph)) begin
			lv = {bc[0], msb};
		end else if (ph == PH_RSTART) begin
			if (bc == 4'd0) lv = 2'b01;
			else if (bc == 4'd1) lv = 2'b11;
			else lv = 2'b10;
		end else if (ph == PH_STOP) begin
			if (bc == 4'd0) lv = 2'b00;
			else if (bc == 4'd1) lv = 2'b10;
			else lv = 2'b11;
		end else begin
			lv = {bc[0], 1'b1};
		end
		return lv;
	endfunction

endpackage

@@ hw/rtl/i2cmra_cfg.sv @@
// ----------------------------------------------------------------------------
// I2C master register access: configuration registers
// Holds the device address, the address-phase enable and the half period.
// ----------------------------------------------------------------------------
module i2cmra_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  logic [1:0]          wr_index,
	input  logic [9:0]          wr_data,
	output i2cmra_pkg::cfg_t    cfg
);

	i2cmra_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address     <= 7'd0;
			cfg_q.use_device_address <= 1'b1;
			cfg_q.half_period_ticks  <= 10'd4;
		end else if (wr_valid) begin
			case (wr_index)
				i2cmra_pkg::CFG_DEVICE_ADDRESS: begin
					cfg_q.device_address <= wr_data[6:0];
				end
				i2cmra_pkg::CFG_USE_DEVICE_ADDRESS: begin
					cfg_q.use_device_address <= wr_data[0];
				end
				i2cmra_pkg::CFG_HALF_PERIOD_TICKS: begin
					cfg_q.half_period_ticks <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/i2cmra_seq.sv @@
// ----------------------------------------------------------------------------
// I2C master register access: bus sequencer
// Holds the transaction state and computes one tick of the bus: line levels,
// half-step timing, byte shifting and phase changes. State advances on commit.
// ----------------------------------------------------------------------------
module i2cmra_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  i2cmra_pkg::item_t    item,
	input  i2cmra_pkg::cfg_t     cfg,
	output i2cmra_pkg::result_t  res
);

	logic [3:0] phase_q;
	logic [3:0] bit_count_q;
	logic [7:0] shift_q;
	logic [9:0] tick_q;
	logic       is_read_q;
	logic [7:0] held_address_q;
	logic [7:0] held_data_q;
	logic [7:0] received_q;

	logic [3:0] ph;
	logic [3:0] nxt;
	logic [3:0] bc;
	logic [7:0] sh;
	logic [9:0] tc;
	logic       rd;
	logic [7:0] ha;
	logic [7:0] hd;
	logic [7:0] rx;
	logic [9:0] hp;
	logic       start;

	always_comb begin
		ph    = phase_q;
		nxt   = i2cmra_pkg::PH_IDLE;
		bc    = bit_count_q;
		sh    = shift_q;
		tc    = tick_q;
		rd    = is_read_q;
		ha    = held_address_q;
		hd    = held_data_q;
		rx    = received_q;
		hp    = (cfg.half_period_ticks == 10'd0) ? 10'd1 : cfg.half_period_ticks;
		res   = '0;
		res.scl     = 1'b1;
		res.sda_out = 1'b1;

		start = (phase_q == i2cmra_pkg::PH_IDLE) &&
			(item.kind == i2cmra_pkg::KIND_WRITE || item.kind == i2cmra_pkg::KIND_READ);
		// The first half of the start condition goes out on the request tick.
		if (start) begin
			rd = (item.kind == i2cmra_pkg::KIND_READ);
			ha = item.target_reg;
			hd = item.write_data;
			tc = 10'd0;
			ph = i2cmra_pkg::PH_START;
			bc = 4'd0;
		end

		if (ph != i2cmra_pkg::PH_IDLE) begin
			res.busy_res = 1'b1;
			{res.scl, res.sda_out} = i2cmra_pkg::drive(ph, bc, sh[7]);
			tc = tc + 10'd1;
			if (tc == 10'd0 || tc >= hp) begin
				tc = 10'd0;
				if (bc[0]) begin
					if (ph == i2cmra_pkg::PH_READ) begin
						sh = {sh[6:0], item.sda_in};
					end else if (i2cmra_pkg::is_send_byte(ph)) begin
						sh = {sh[6:0], 1'b0};
					end
				end
				bc = bc + 4'd1;
				if (bc == i2cmra_pkg::halves_of(ph)) begin
					case (ph)
						i2cmra_pkg::PH_START: begin
							nxt = cfg.use_device_address ? i2cmra_pkg::PH_DEVW
								: i2cmra_pkg::PH_REG;
						end
						i2cmra_pkg::PH_DEVW:   nxt = i2cmra_pkg::PH_ACK1;
						i2cmra_pkg::PH_ACK1:   nxt = i2cmra_pkg::PH_REG;
						i2cmra_pkg::PH_REG:    nxt = i2cmra_pkg::PH_ACK2;
						i2cmra_pkg::PH_ACK2: begin
							if (rd) begin
								nxt = cfg.use_device_address ? i2cmra_pkg::PH_RSTART
									: i2cmra_pkg::PH_READ;
							end else begin
								nxt = i2cmra_pkg::PH_DATA;
							end
						end
						i2cmra_pkg::PH_DATA:   nxt = i2cmra_pkg::PH_ACK3;
						i2cmra_pkg::PH_ACK3:   nxt = i2cmra_pkg::PH_STOP;
						i2cmra_pkg::PH_RSTART: nxt = i2cmra_pkg::PH_DEVR;
						i2cmra_pkg::PH_DEVR:   nxt = i2cmra_pkg::PH_ACK4;
						i2cmra_pkg::PH_ACK4:   nxt = i2cmra_pkg::PH_READ;
						i2cmra_pkg::PH_READ:   nxt = i2cmra_pkg::PH_NACK;
						i2cmra_pkg::PH_NACK:   nxt = i2cmra_pkg::PH_STOP;
						default: begin
							nxt = i2cmra_pkg::PH_IDLE;
							res.done_res = 1'b1;
						end
					endcase
					if (ph == i2cmra_pkg::PH_READ) begin
						rx = sh;
					end
					ph = nxt;
					bc = 4'd0;
					case (nxt)
						i2cmra_pkg::PH_DEVW: sh = {cfg.device_address, 1'b0};
						i2cmra_pkg::PH_REG:  sh = ha;
						i2cmra_pkg::PH_DATA: sh = hd;
						i2cmra_pkg::PH_DEVR: sh = {cfg.device_address, 1'b1};
						i2cmra_pkg::PH_READ: sh = 8'd0;
						default: begin
						end
					endcase
				end
			end
		end
		res.read_data = rx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= i2cmra_pkg::PH_IDLE;
			bit_count_q    <= 4'd0;
			shift_q        <= 8'd0;
			tick_q         <= 10'd0;
			is_read_q      <= 1'b0;
			held_address_q <= 8'd0;
			held_data_q    <= 8'd0;
			received_q     <= 8'd0;
		end else if (commit) begin
			phase_q        <= ph;
			bit_count_q    <= bc;
			shift_q        <= sh;
			tick_q         <= tc;
			is_read_q      <= rd;
			held_address_q <= ha;
			held_data_q    <= hd;
			received_q     <= rx;
		end
	end

endmodule

@@ hw/rtl/i2c_master_register_access_core.sv @@
// ----------------------------------------------------------------------------
// I2C master register access core
// Channel   | handshake                     | contents
// input     | in_valid / in_stall           | kind, target_reg, write_data, sda_in
// output    | out_valid / out_stall         | scl, sda_out, busy_res, done_res, read_data
// config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// Every input transfer is one bus tick and yields exactly one output transfer.
// One tick can be accepted per cycle while in_stall is low; its result is loaded
// into the result register and transfers from there when out_stall is low.
// The sequencer state advances when a tick moves from the input register into
// the result register, which happens whenever that register is empty or drained.
// A stalled output holds its result, and in_stall rises only while the input
// register is full behind it. Reset is asynchronous and leaves the bus idle.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] target_reg,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl,
	output logic       sda_out,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	logic                 valid_s1;
	i2cmra_pkg::item_t    item_s1;
	logic                 valid_s2;
	i2cmra_pkg::result_t  res_s2;
	i2cmra_pkg::result_t  res;
	i2cmra_pkg::cfg_t     cfg;
	logic                 advance;
	logic                 in_take;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;

	i2cmra_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	i2cmra_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.kind       <= kind;
			item_s1.target_reg <= target_reg;
			item_s1.write_data <= write_data;
			item_s1.sda_in     <= sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign scl       = res_s2.scl;
	assign sda_out   = res_s2.sda_out;
	assign busy_res  = res_s2.busy_res;
	assign done_res  = res_s2.done_res;
	assign read_data = res_s2.read_data;

endmodule

@@ hw/rtl/i2cmra_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master register access: port checker
// Watches the top-level ports for bus framing and flow-control slips.
// ----------------------------------------------------------------------------
module i2cmra_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl,
	input logic       sda_out,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data
);

	// A finished stop condition belongs to a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	// An idle bus leaves both lines high.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl && sda_out)
		else $error("idle bus not released");

	// The input side stalls only when a result is waiting and held back.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A held result keeps its line levels and read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scl) && $stable(sda_out)
			&& $stable(read_data))
		else $error("stalled result changed");

endmodule

bind i2c_master_register_access_core i2cmra_checker u_i2cmra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.scl       (scl),
	.sda_out   (sda_out),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.read_data (read_data)
);
